>>> hdl/css_pkg.sv
// Package for the cocktail shaker sorter: sizes, beat payload types,
// controller/datapath command and status types. No dependencies.
package css_pkg;

   // Store sizing
   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int TALLY_W = 11;

   // Input beat
   typedef struct packed {
      logic signed [DATA_W-1:0] element_value;
      logic                     is_final;
   } css_req_type;

   // Output beat
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     end_of_run;
      logic [TALLY_W-1:0]       comparisons;
      logic [TALLY_W-1:0]       exchanges;
   } css_rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_F_INIT,
      OP_F_TAKE,
      OP_F_CMP,
      OP_F_END,
      OP_B_INIT,
      OP_B_TAKE,
      OP_B_CMP,
      OP_B_END,
      OP_OUT_START,
      OP_OUT_SHOW,
      OP_OUT_NEXT,
      OP_OUT_DONE
   } css_op_type;

   typedef struct packed {
      css_op_type op;
   } css_cmd_type;

   typedef struct packed {
      logic load_last;  // beat in flight closes the set
      logic single;     // set holds one element
      logic fwd_last;   // forward compare at upper bound
      logic bwd_last;   // backward compare at lower bound
      logic quiet;      // no swap in the current pass
      logic span_ok;    // lower bound + 1 below upper bound
      logic out_last;   // result register holds the greatest value
   } css_status_type;

endpackage

>>> hdl/css_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module css_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/css_ctrl.sv
// Sequencer for the cocktail shaker sorter: load, forward and backward
// passes, result emission. Depends on css_pkg.
module css_ctrl
   import css_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  css_status_type status,
   output css_cmd_type    cmd
);

   typedef enum logic [11:0] {
      S_LOAD    = 12'b0000_0000_0001,
      S_F_INIT  = 12'b0000_0000_0010,
      S_F_TAKE  = 12'b0000_0000_0100,
      S_F_CMP   = 12'b0000_0000_1000,
      S_F_END   = 12'b0000_0001_0000,
      S_B_INIT  = 12'b0000_0010_0000,
      S_B_TAKE  = 12'b0000_0100_0000,
      S_B_CMP   = 12'b0000_1000_0000,
      S_B_END   = 12'b0001_0000_0000,
      S_O_START = 12'b0010_0000_0000,
      S_O_SHOW  = 12'b0100_0000_0000,
      S_O_HOLD  = 12'b1000_0000_0000
   } css_state_type;

   css_state_type state_ff, state_in;

   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = (state_ff == S_O_HOLD);

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (status.load_last) begin
                  state_in = status.single ? S_O_START : S_F_INIT;
               end
            end
         end
         S_F_INIT: begin
            cmd.op   = OP_F_INIT;
            state_in = S_F_TAKE;
         end
         S_F_TAKE: begin
            cmd.op   = OP_F_TAKE;
            state_in = S_F_CMP;
         end
         S_F_CMP: begin
            cmd.op = OP_F_CMP;
            if (status.fwd_last) begin
               state_in = S_F_END;
            end
         end
         S_F_END: begin
            cmd.op   = OP_F_END;
            state_in = (status.quiet || !status.span_ok) ? S_O_START : S_B_INIT;
         end
         S_B_INIT: begin
            cmd.op   = OP_B_INIT;
            state_in = S_B_TAKE;
         end
         S_B_TAKE: begin
            cmd.op   = OP_B_TAKE;
            state_in = S_B_CMP;
         end
         S_B_CMP: begin
            cmd.op = OP_B_CMP;
            if (status.bwd_last) begin
               state_in = S_B_END;
            end
         end
         S_B_END: begin
            cmd.op   = OP_B_END;
            state_in = (status.quiet || !status.span_ok) ? S_O_START : S_F_INIT;
         end
         S_O_START: begin
            cmd.op   = OP_OUT_START;
            state_in = S_O_SHOW;
         end
         S_O_SHOW: begin
            cmd.op   = OP_OUT_SHOW;
            state_in = S_O_HOLD;
         end
         S_O_HOLD: begin
            if (!rsp_stall) begin
               if (status.out_last) begin
                  cmd.op   = OP_OUT_DONE;
                  state_in = S_LOAD;
               end else begin
                  cmd.op   = OP_OUT_NEXT;
                  state_in = S_O_SHOW;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/css_datapath.sv
// Datapath of the cocktail shaker sorter: element RAM, carried element,
// bounds, pointers, tallies and the result register. Depends on css_pkg, css_ram.
module css_datapath
   import css_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  css_req_type    req_data,
   input  css_cmd_type    cmd,
   output css_status_type status,
   output css_rsp_type    rsp_data
);

   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [ADDR_W-1:0]        lo_ff, lo_in;
   logic [ADDR_W-1:0]        hi_ff, hi_in;
   logic [ADDR_W-1:0]        last_ff, last_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;
   logic [TALLY_W-1:0]       cmp_ff, cmp_in;
   logic [TALLY_W-1:0]       swp_ff, swp_in;
   logic                     quiet_ff, quiet_in;
   logic signed [DATA_W-1:0] carry_ff, carry_in;
   css_rsp_type              rsp_ff, rsp_in;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_value;
   logic                     fwd_swap;
   logic                     bwd_swap;

   css_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_value = $signed(rd_data);
   // Forward: carried element is the left one; backward: it is the right one
   assign fwd_swap = (carry_ff > rd_value);
   assign bwd_swap = (rd_value > carry_ff);

   // Status toward the controller
   always_comb begin
      status.load_last = req_data.is_final || (fill_ff == CNT_W'(DEPTH - 1));
      status.single    = (fill_ff == '0);
      status.fwd_last  = (ADDR_W'(ptr_ff + ADDR_W'(1)) == hi_ff);
      status.bwd_last  = (ADDR_W'(ptr_ff - ADDR_W'(1)) == lo_ff);
      status.quiet     = quiet_ff;
      status.span_ok   = (({1'b0, lo_ff} + (ADDR_W + 1)'(1)) < {1'b0, hi_ff});
      status.out_last  = rsp_ff.end_of_run;
   end

   // Operation decode
   always_comb begin
      fill_in  = fill_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      last_in  = last_ff;
      ptr_in   = ptr_ff;
      cmp_in   = cmp_ff;
      swp_in   = swp_ff;
      quiet_in = quiet_ff;
      carry_in = carry_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = carry_ff;
      rd_addr  = '0;
      unique case (cmd.op)
         OP_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = fill_ff[ADDR_W-1:0];
            wr_data = req_data.element_value;
            fill_in = CNT_W'(fill_ff + CNT_W'(1));
            if (status.load_last) begin
               fill_in = '0;
               lo_in   = '0;
               hi_in   = fill_ff[ADDR_W-1:0];
               last_in = fill_ff[ADDR_W-1:0];
               cmp_in  = '0;
               swp_in  = '0;
            end
         end
         OP_F_INIT: begin
            rd_addr  = lo_ff;
            ptr_in   = lo_ff;
            quiet_in = 1'b1;
         end
         OP_F_TAKE: begin
            carry_in = rd_value;
            rd_addr  = ADDR_W'(ptr_ff + ADDR_W'(1));
         end
         // Drop the smaller one behind, carry the larger one up
         OP_F_CMP: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            wr_data  = fwd_swap ? rd_value : carry_ff;
            carry_in = fwd_swap ? carry_ff : rd_value;
            cmp_in   = TALLY_W'(cmp_ff + TALLY_W'(1));
            if (fwd_swap) begin
               swp_in   = TALLY_W'(swp_ff + TALLY_W'(1));
               quiet_in = 1'b0;
            end
            ptr_in  = ADDR_W'(ptr_ff + ADDR_W'(1));
            rd_addr = ADDR_W'(ptr_ff + ADDR_W'(2));
         end
         OP_F_END: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = carry_ff;
            hi_in   = ADDR_W'(hi_ff - ADDR_W'(1));
         end
         OP_B_INIT: begin
            rd_addr  = hi_ff;
            ptr_in   = hi_ff;
            quiet_in = 1'b1;
         end
         OP_B_TAKE: begin
            carry_in = rd_value;
            rd_addr  = ADDR_W'(ptr_ff - ADDR_W'(1));
         end
         // Drop the larger one behind, carry the smaller one down
         OP_B_CMP: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            wr_data  = bwd_swap ? rd_value : carry_ff;
            carry_in = bwd_swap ? carry_ff : rd_value;
            cmp_in   = TALLY_W'(cmp_ff + TALLY_W'(1));
            if (bwd_swap) begin
               swp_in   = TALLY_W'(swp_ff + TALLY_W'(1));
               quiet_in = 1'b0;
            end
            ptr_in  = ADDR_W'(ptr_ff - ADDR_W'(1));
            rd_addr = ADDR_W'(ptr_ff - ADDR_W'(2));
         end
         OP_B_END: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = carry_ff;
            lo_in   = ADDR_W'(lo_ff + ADDR_W'(1));
         end
         OP_OUT_START: begin
            rd_addr = '0;
            ptr_in  = '0;
         end
         OP_OUT_SHOW: begin
            rsp_in.sorted_value = rd_value;
            rsp_in.end_of_run   = (ptr_ff == last_ff);
            rsp_in.comparisons  = cmp_ff;
            rsp_in.exchanges    = swp_ff;
         end
         OP_OUT_NEXT: begin
            rd_addr = ADDR_W'(ptr_ff + ADDR_W'(1));
            ptr_in  = ADDR_W'(ptr_ff + ADDR_W'(1));
         end
         OP_OUT_DONE: begin
            fill_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         lo_ff   <= '0;
         hi_ff   <= '0;
         cmp_ff  <= '0;
         swp_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         cmp_ff  <= cmp_in;
         swp_ff  <= swp_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      ptr_ff   <= ptr_in;
      quiet_ff <= quiet_in;
      carry_ff <= carry_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hdl/cocktail_shaker_sorter_unit.sv
// Cocktail shaker sorter, top level: sequencer plus datapath.
// Depends on css_pkg, css_ctrl, css_datapath (css_ram).
//
// Elements load at one beat per cycle into a 64-entry RAM. The beat with
// is_final set, or the beat that fills the store, starts the sort, and the
// input stalls until the last result beat of that set has been taken. The
// single-write, single-read RAM port pair sets the sort time. Each pass has
// a start step, a take step that loads the carried element, one compare step
// per comparison and an end step that writes the carried element back, and
// passes run until one makes no swap or the bounds meet. Results leave in
// ascending order, each beat only after the one before it is taken, with the
// comparison and swap counts of the sort; end_of_run marks the greatest value.
module cocktail_shaker_sorter_unit
   import css_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  css_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output css_rsp_type rsp_data
);

   css_cmd_type    cmd;
   css_status_type status;

   css_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   css_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> test/css_order_checker.sv
// Result checker for the cocktail shaker sorter: watches both beat channels,
// sorts each accepted set on its own and compares every result beat.
// Depends on css_pkg for sizes and the beat payload types.
`timescale 1ns / 100ps

module css_order_checker
   import css_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  css_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  css_rsp_type rsp_data,
   output int          pending,
   output int          fault_count
);

   // Elements of the set being collected, and the sorted beats still owed
   logic signed [DATA_W-1:0] set_buf [DEPTH];
   int                       set_fill;
   css_rsp_type              sorted_queue [$];

   initial begin
      pending     = 0;
      fault_count = 0;
      set_fill    = 0;
   end

   task automatic report_mismatch(input string what);
      fault_count++;
      $display("%0t ns: sorter mismatch: %s", $time, what);
   endtask

   // Shaker sort of set_buf[0 .. n-1] in place, with comparison and swap tallies
   task automatic shake_sort(input int n, output logic [TALLY_W-1:0] cmp_n,
                             output logic [TALLY_W-1:0] swp_n);
      int                       lo;
      int                       hi;
      int                       i;
      bit                       moved;
      bit                       done;
      logic signed [DATA_W-1:0] held;
      lo    = 0;
      hi    = n - 1;
      cmp_n = '0;
      swp_n = '0;
      done  = 1'b0;
      while (!done) begin
         // forward pass carries the largest value up to hi
         moved = 1'b0;
         for (i = lo; i < hi; i++) begin
            cmp_n++;
            if (set_buf[i] > set_buf[i+1]) begin
               held         = set_buf[i];
               set_buf[i]   = set_buf[i+1];
               set_buf[i+1] = held;
               swp_n++;
               moved = 1'b1;
            end
         end
         hi--;
         if (!moved) begin
            done = 1'b1;
         end else begin
            // backward pass carries the smallest value down to lo
            moved = 1'b0;
            for (i = hi; i > lo; i--) begin
               cmp_n++;
               if (set_buf[i-1] > set_buf[i]) begin
                  held         = set_buf[i];
                  set_buf[i]   = set_buf[i-1];
                  set_buf[i-1] = held;
                  swp_n++;
                  moved = 1'b1;
               end
            end
            lo++;
            if (!moved) done = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      css_rsp_type          entry;
      css_rsp_type          wanted;
      logic [TALLY_W-1:0]   cmp_n;
      logic [TALLY_W-1:0]   swp_n;
      int                   k;
      if (reset) begin
         set_fill = 0;
      end else begin
         // result beat: compare against the oldest owed value
         if (rsp_valid && !rsp_stall) begin
            if (sorted_queue.size() == 0) begin
               report_mismatch($sformatf("result beat %0d with nothing owed",
                                         rsp_data.sorted_value));
            end else begin
               wanted = sorted_queue.pop_front();
               if (rsp_data.sorted_value !== wanted.sorted_value)
                  report_mismatch($sformatf("sorted_value %0d, want %0d",
                                            rsp_data.sorted_value, wanted.sorted_value));
               if (rsp_data.end_of_run !== wanted.end_of_run)
                  report_mismatch($sformatf("end_of_run %b, want %b",
                                            rsp_data.end_of_run, wanted.end_of_run));
               if (rsp_data.comparisons !== wanted.comparisons)
                  report_mismatch($sformatf("comparisons %0d, want %0d",
                                            rsp_data.comparisons, wanted.comparisons));
               if (rsp_data.exchanges !== wanted.exchanges)
                  report_mismatch($sformatf("exchanges %0d, want %0d",
                                            rsp_data.exchanges, wanted.exchanges));
            end
         end
         // input beat: collect; last beat or full store closes the set
         if (req_valid && !req_stall) begin
            set_buf[set_fill] = req_data.element_value;
            set_fill++;
            if (req_data.is_final || set_fill == DEPTH) begin
               shake_sort(set_fill, cmp_n, swp_n);
               for (k = 0; k < set_fill; k++) begin
                  entry.sorted_value = set_buf[k];
                  entry.end_of_run   = (k == set_fill - 1);
                  entry.comparisons  = cmp_n;
                  entry.exchanges    = swp_n;
                  sorted_queue.push_back(entry);
               end
               set_fill = 0;
            end
         end
      end
      pending = sorted_queue.size();
   end

endmodule

>>> test/cocktail_shaker_sorter_unit_tb.sv
// Testbench top for cocktail_shaker_sorter_unit: clock, reset, beat stimulus
// and the verdict. Depends on css_pkg, the block and css_order_checker.
`timescale 1ns / 100ps

module cocktail_shaker_sorter_unit_tb;
   import css_pkg::*;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int IDLE_PCT     = 22;
   localparam int RANDOM_BEATS = 126;
   localparam int QUIET_LIMIT  = 20000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   css_req_type req_data  = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   css_rsp_type rsp_data;
   int          pending;
   int          fault_count;

   bit          steady       = 1'b0;
   int          quiet_cycles = 0;
   int          beats_sent   = 0;
   logic signed [DATA_W-1:0] set_vals [$];

   cocktail_shaker_sorter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   css_order_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .pending     (pending),
      .fault_count (fault_count)
   );

   always #4 clock = ~clock;

   // Receiver stalls at random except in steady stretches
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   // Watchdog: too long without any beat moving ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("cocktail_shaker_sorter_unit_tb: done, errors");
         $finish;
      end
   end

   // One input beat, with random idle cycles ahead of it
   task automatic send_beat(input logic signed [DATA_W-1:0] value, input logic fin);
      while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_data.element_value <= value;
      req_data.is_final      <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Send set_vals; close marks the last beat as final
   task automatic send_set(input bit close);
      int k;
      for (k = 0; k < set_vals.size(); k++)
         send_beat(set_vals[k], close && (k == set_vals.size() - 1));
   endtask

   // Hold the sender until all owed results are out
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Random set: full range, duplicates, nearly sorted, descending or extremes
   task automatic build_set(input int n, input int mode);
      int k;
      set_vals.delete();
      for (k = 0; k < n; k++) begin
         case (mode)
            0: set_vals.push_back($urandom);
            1: set_vals.push_back($urandom_range(15) - 8);
            2: set_vals.push_back(k * 1000 + $urandom_range(1500));
            3: set_vals.push_back((n - k) * 1000 - 5000);
            default: begin
               case ($urandom_range(4))
                  0: set_vals.push_back(VAL_MIN);
                  1: set_vals.push_back(VAL_MAX);
                  2: set_vals.push_back(0);
                  3: set_vals.push_back(-1);
                  default: set_vals.push_back($urandom);
               endcase
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int n;
      int set_no;
      int start_beats;
      bit close;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: single elements, pairs, extremes, quiet forward pass,
      // quiet backward pass, full reversal
      set_vals = '{VAL_MIN};                              send_set(1'b1);
      set_vals = '{VAL_MAX};                              send_set(1'b1);
      set_vals = '{VAL_MAX, VAL_MIN};                     send_set(1'b1);
      set_vals = '{VAL_MIN, VAL_MAX};                     send_set(1'b1);
      set_vals = '{VAL_MAX, 0, -1, VAL_MIN, 1, VAL_MAX};  send_set(1'b1);
      set_vals = '{-3, -1, 2, 9};                         send_set(1'b1);
      set_vals = '{1, 3, 2, 4};                           send_set(1'b1);
      set_vals = '{9, 2, -1, -3};                         send_set(1'b1);

      // Random sets, mostly small; one fills the store without a final flag
      set_no      = 0;
      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         steady <= (set_no >= 4 && set_no < 8);
         close = 1'b1;
         if (set_no == 10) begin
            n     = DEPTH;
            close = 1'b0;
         end else if ($urandom_range(9) == 0) begin
            n = $urandom_range(20, 11);
         end else begin
            n = $urandom_range(8, 1);
         end
         build_set(n, $urandom_range(4));
         send_set(close);
         if (set_no == 3) drain_results();
         set_no++;
      end
      steady <= 1'b0;

      // Wind down and give the verdict
      drain_results();
      repeat (40) @(posedge clock);
      if (fault_count == 0)
         $display("cocktail_shaker_sorter_unit_tb: done, clean");
      else
         $display("cocktail_shaker_sorter_unit_tb: done, errors");
      $finish;
   end

endmodule
